>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define HSVC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hsvc: assertion failed");

// boolean condition must never be seen at a clock edge out of reset
`define HSVC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("hsvc: forbidden condition seen");

`endif

>>> hw/rtl/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types, constants and arithmetic helpers of the HSV to RGB converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsvc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam logic [15:0] FullSq   = 16'd65025;
  localparam logic [7:0]  FullScl  = 8'd255;

  typedef enum logic [2:0] {
    SEXT_0 = 3'd0,
    SEXT_1 = 3'd1,
    SEXT_2 = 3'd2,
    SEXT_3 = 3'd3,
    SEXT_4 = 3'd4,
    SEXT_5 = 3'd5
  } sextant_e;

  // classified item travelling from the front to the back
  typedef struct packed {
    sextant_e           sext;
    logic [ChanW-1:0]   frac;
    logic [ChanW-1:0]   sat;
    logic [ChanW-1:0]   val;
  } hsv_tok_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // queue status seen by the top level checks
  typedef struct packed {
    logic push;
    logic pop;
    logic empty;
    logic full;
  } queue_stat_t;

  // floor(z / 255) for z up to 255 * 65025: estimate by z * 257 / 2^16,
  // which is low by at most one, then fix up with one remainder compare
  function automatic logic [15:0] div255(input logic [23:0] z);
    logic [31:0] sum;
    logic [15:0] est;
    logic [23:0] back;
    logic [23:0] rem;
    sum  = {8'd0, z} + {z, 8'd0};
    est  = sum[31:16];
    back = {est, 8'd0} - {8'd0, est};
    rem  = z - back;
    if (rem >= 24'd255) begin
      est = est + 16'd1;
    end
    return est;
  endfunction

endpackage

>>> hw/rtl/hsvc_if.sv
// ----------------------------------------------------------------------------
// hsvc_if
// Valid/ready channels for HSV pixels in and RGB pixels out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsvc_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] value;

  modport source (output valid, output hue, output saturation, output value,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input value,
                  output ready);
endinterface

interface hsvc_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

>>> hw/rtl/hsvc_front.sv
// ----------------------------------------------------------------------------
// hsvc_front
// Accepts pixels, finds the hue sextant and the fraction within it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsvc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsvc_pkg::hsv_tok_t out_tok_o
);
  import hsvc_pkg::*;

  logic       valid_q, valid_d;
  hsv_tok_t   tok_q, tok_d;
  logic [10:0] h6;
  logic [10:0] base;
  logic       load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign h6         = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  // hue 255 lands on 6 * 255 with fraction zero and shares the last order
  always_comb begin
    tok_d.sat = saturation_i;
    tok_d.val = value_i;
    priority if (h6 >= 11'd1275) begin
      tok_d.sext = SEXT_5;
      base       = (h6 >= 11'd1530) ? 11'd1530 : 11'd1275;
    end else if (h6 >= 11'd1020) begin
      tok_d.sext = SEXT_4;
      base       = 11'd1020;
    end else if (h6 >= 11'd765) begin
      tok_d.sext = SEXT_3;
      base       = 11'd765;
    end else if (h6 >= 11'd510) begin
      tok_d.sext = SEXT_2;
      base       = 11'd510;
    end else if (h6 >= 11'd255) begin
      tok_d.sext = SEXT_1;
      base       = 11'd255;
    end else begin
      tok_d.sext = SEXT_0;
      base       = 11'd0;
    end
    tok_d.frac = 8'(h6 - base);
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q <= tok_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;

endmodule

>>> hw/rtl/hsvc_queue.sv
// ----------------------------------------------------------------------------
// hsvc_queue
// Short register FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsvc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  hsvc_pkg::hsv_tok_t    push_tok_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output hsvc_pkg::hsv_tok_t    pop_tok_o,
  output hsvc_pkg::queue_stat_t stat_o
);
  import hsvc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hsv_tok_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop, empty, full;

  assign empty        = (cnt_q == '0);
  assign full         = (cnt_q == FullCnt);
  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign push         = push_valid_i && !full;
  assign pop          = pop_ready_i && !empty;
  assign pop_tok_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  assign stat_o.push  = push;
  assign stat_o.pop   = pop;
  assign stat_o.empty = empty;
  assign stat_o.full  = full;

endmodule

>>> hw/rtl/hsvc_back.sv
// ----------------------------------------------------------------------------
// hsvc_back
// Four-stage elastic pipeline computing p, q, t and the channel order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsvc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsvc_pkg::hsv_tok_t in_tok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsvc_pkg::rgb_t     out_rgb_o
);
  import hsvc_pkg::*;

  // stage valids and advance enables, index 0 is the first stage
  logic [3:0] vld_q, vld_d;
  logic [3:0] adv;

  // stage A: saturation products
  sextant_e    a_sext_q;
  logic [7:0]  a_sat_q, a_val_q;
  logic [15:0] a_sf_q, a_sfc_q;
  // stage B: value products
  sextant_e    b_sext_q;
  logic [7:0]  b_val_q;
  logic [15:0] b_zp_q;
  logic [23:0] b_zq_q, b_zt_q;
  // stage C: first division by 255
  sextant_e    c_sext_q;
  logic [7:0]  c_val_q;
  logic [7:0]  c_p_q;
  logic [15:0] c_q1_q, c_t1_q;
  // stage D: output register
  rgb_t        d_rgb_q, d_rgb_d;

  logic [7:0]  fc;
  logic [15:0] zp_d;
  logic [15:0] p_full, q_full, t_full;
  logic [7:0]  p_v, q_v, t_v;

  assign adv[3] = !vld_q[3] || out_ready_i;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_ready_o = adv[0];

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) vld_d[0] = in_valid_i;
    if (adv[1]) vld_d[1] = vld_q[0];
    if (adv[2]) vld_d[2] = vld_q[1];
    if (adv[3]) vld_d[3] = vld_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign fc   = FullScl - in_tok_i.frac;
  assign zp_d = 16'(a_val_q) * 16'(FullScl - a_sat_q);

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      a_sext_q <= in_tok_i.sext;
      a_sat_q  <= in_tok_i.sat;
      a_val_q  <= in_tok_i.val;
      a_sf_q   <= 16'(in_tok_i.sat) * 16'(in_tok_i.frac);
      a_sfc_q  <= 16'(in_tok_i.sat) * 16'(fc);
    end
    if (adv[1] && vld_q[0]) begin
      b_sext_q <= a_sext_q;
      b_val_q  <= a_val_q;
      b_zp_q   <= zp_d;
      b_zq_q   <= 24'(a_val_q) * 24'(FullSq - a_sf_q);
      b_zt_q   <= 24'(a_val_q) * 24'(FullSq - a_sfc_q);
    end
    if (adv[2] && vld_q[1]) begin
      c_sext_q <= b_sext_q;
      c_val_q  <= b_val_q;
      c_p_q    <= p_full[7:0];
      c_q1_q   <= div255(b_zq_q);
      c_t1_q   <= div255(b_zt_q);
    end
    if (adv[3] && vld_q[2]) begin
      d_rgb_q <= d_rgb_d;
    end
  end

  // floor(floor(z/255)/255) equals floor(z/65025)
  assign p_full = div255({8'd0, b_zp_q});
  assign q_full = div255({8'd0, c_q1_q});
  assign t_full = div255({8'd0, c_t1_q});
  assign p_v    = c_p_q;
  assign q_v    = q_full[7:0];
  assign t_v    = t_full[7:0];

  // zero saturation makes p, q and t all equal value, so grey needs no path
  always_comb begin
    unique case (c_sext_q)
      SEXT_0:  d_rgb_d = '{red: c_val_q, green: t_v,     blue: p_v};
      SEXT_1:  d_rgb_d = '{red: q_v,     green: c_val_q, blue: p_v};
      SEXT_2:  d_rgb_d = '{red: p_v,     green: c_val_q, blue: t_v};
      SEXT_3:  d_rgb_d = '{red: p_v,     green: q_v,     blue: c_val_q};
      SEXT_4:  d_rgb_d = '{red: t_v,     green: p_v,     blue: c_val_q};
      default: d_rgb_d = '{red: c_val_q, green: p_v,     blue: q_v};
    endcase
  end

  assign out_valid_o = vld_q[3];
  assign out_rgb_o   = d_rgb_q;

endmodule

>>> hw/rtl/hsv_to_rgb_converter.sv
// One pixel per clock: an 8-bit hue, saturation, value triple goes in and an
// 8-bit red, green, blue triple comes out, in order, one result per pixel.
// A new pixel is taken every cycle while the output side keeps up; results pass
// through the front register, the queue and four arithmetic stages, which hold the
// chain of multiplications and the two divide-by-255 steps in the back.
// Pixels keep flowing into the front and queue while the output stalls until
// the pipeline fills; hue 255 closes the turn and is treated as sextant five.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming HSV to RGB pixel converter, exact integer arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hsv_to_rgb_converter #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hsvc_hsv_if.sink          hsv_i,
  hsvc_rgb_if.source        rgb_o
);
  import hsvc_pkg::*;

  logic        fr_valid, fr_ready;
  hsv_tok_t    fr_tok;
  logic        bk_valid, bk_ready;
  hsv_tok_t    bk_tok;
  rgb_t        rgb;
  queue_stat_t q_stat;

  hsvc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (hsv_i.valid),
    .in_ready_o   (hsv_i.ready),
    .hue_i        (hsv_i.hue),
    .saturation_i (hsv_i.saturation),
    .value_i      (hsv_i.value),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .out_tok_o    (fr_tok)
  );

  hsvc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_tok_i   (fr_tok),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_tok_o    (bk_tok),
    .stat_o       (q_stat)
  );

  hsvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_tok_i    (bk_tok),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_rgb_o   (rgb)
  );

  assign rgb_o.red   = rgb.red;
  assign rgb_o.green = rgb.green;
  assign rgb_o.blue  = rgb.blue;

  `HSVC_ASSERT_NEVER(a_queue_full_and_empty, q_stat.full && q_stat.empty)
  `HSVC_ASSERT(a_pop_needs_item, q_stat.pop |-> !q_stat.empty)
  `HSVC_ASSERT(a_push_leaves_item, q_stat.push |=> !q_stat.empty)
  `HSVC_ASSERT_NEVER(a_push_when_full, q_stat.push && q_stat.full)

endmodule

>>> tb/hsv_to_rgb_converter_test.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking bench for the HSV to RGB pixel converter. A queue-fed driver
// streams pixels and a monitor checks every RGB result, field by field,
// against an integer model of the conversion. Both sides idle in random bursts until the quiet tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;

  import hsvc_pkg::*;

  localparam int unsigned FullScale  = 255;
  localparam int unsigned FullSquare = 65025;
  localparam int          RandItems  = 760;
  localparam int          TailItems  = 120;
  localparam int          DrainWait  = 40;
  localparam longint      CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_pixel_t;

  logic clk;
  logic rst_n;

  hsvc_hsv_if hsv_ch ();
  hsvc_rgb_if rgb_ch ();

  hsv_to_rgb_converter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .hsv_i  (hsv_ch),
    .rgb_o  (rgb_ch)
  );

  hsv_pixel_t pending_pixels[$];
  rgb_t       expected_rgb[$];
  int         error_count = 0;
  longint     cycle_count = 0;
  logic       all_loaded  = 1'b0;
  logic       quiet_tail  = 1'b0;

  // integer HSV to RGB, truncating every quotient
  function automatic rgb_t hsv_to_rgb(hsv_pixel_t px);
    logic [31:0] h6, idx, f, s, v, p, q, t;
    sextant_e    sx;
    rgb_t        c;
    s = {24'd0, px.sat};
    v = {24'd0, px.val};
    if (px.sat == 8'd0) begin
      c.red   = px.val;
      c.green = px.val;
      c.blue  = px.val;
      return c;
    end
    h6  = {24'd0, px.hue} * 6;
    idx = h6 / FullScale;
    f   = h6 - FullScale * idx;
    p   = (v * (FullScale - s)) / FullScale;
    q   = (v * (FullSquare - s * f)) / FullSquare;
    t   = (v * (FullSquare - s * (FullScale - f))) / FullSquare;
    // hue 255 lands in sextant six and wraps onto the last order
    sx  = (idx > 5) ? SEXT_5 : sextant_e'(idx[2:0]);
    case (sx)
      SEXT_0: begin c.red = v[7:0]; c.green = t[7:0]; c.blue = p[7:0]; end
      SEXT_1: begin c.red = q[7:0]; c.green = v[7:0]; c.blue = p[7:0]; end
      SEXT_2: begin c.red = p[7:0]; c.green = v[7:0]; c.blue = t[7:0]; end
      SEXT_3: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v[7:0]; end
      SEXT_4: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v[7:0]; end
      default: begin c.red = v[7:0]; c.green = p[7:0]; c.blue = q[7:0]; end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hsv_pixel_t rand_pixel();
    hsv_pixel_t px;
    logic [7:0] edges[12] = '{42, 43, 84, 85, 127, 128, 169, 170, 212, 213, 254, 255};
    px.hue = ($urandom_range(0, 7) == 0) ? edges[$urandom_range(0, 11)] : rand_byte();
    px.sat = ($urandom_range(0, 6) == 0) ? 8'd0 : rand_byte();
    px.val = rand_byte();
    return px;
  endfunction

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || expected_rgb.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    hsv_ch.valid      = 1'b0;
    hsv_ch.hue        = 8'd0;
    hsv_ch.saturation = 8'd0;
    hsv_ch.value      = 8'd0;
    rgb_ch.ready      = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("hsv_to_rgb_converter_test: FAIL");
      $finish;
    end
  end

  // driver: holds an offered item until it is taken
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk or negedge rst_n) begin
    hsv_pixel_t px;
    if (!rst_n) begin
      hsv_ch.valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else if (!hsv_ch.valid || hsv_ch.ready) begin
      if (all_loaded && pending_pixels.size() < TailItems) quiet_tail <= 1'b1;
      if (send_gap > 0) begin
        send_gap--;
        hsv_ch.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        px = pending_pixels.pop_front();
        hsv_ch.hue        <= px.hue;
        hsv_ch.saturation <= px.sat;
        hsv_ch.value      <= px.val;
        hsv_ch.valid      <= 1'b1;
        // an offered item is always taken, in order, so predict it now
        expected_rgb.push_back(hsv_to_rgb(px));
        if (send_calm > 0) begin
          send_calm--;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          send_gap  = $urandom_range(1, 14);
          send_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
        end
      end else begin
        hsv_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each taken result, stalls in random bursts
  int recv_gap  = 0;
  int recv_calm = 0;

  always @(posedge clk or negedge rst_n) begin
    rgb_t want;
    if (!rst_n) begin
      rgb_ch.ready <= 1'b0;
      recv_gap  = 0;
      recv_calm = 0;
    end else begin
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (expected_rgb.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d",
                 rgb_ch.red, rgb_ch.green, rgb_ch.blue);
          error_count++;
        end else begin
          want = expected_rgb.pop_front();
          check_channel("red", want.red, rgb_ch.red);
          check_channel("green", want.green, rgb_ch.green);
          check_channel("blue", want.blue, rgb_ch.blue);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rgb_ch.ready <= 1'b0;
      end else begin
        rgb_ch.ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          recv_gap  = $urandom_range(1, 14);
          recv_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
        end
      end
    end
  end

  initial begin
    hsv_pixel_t directed[$];
    directed = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd0,   8'd0,   8'd255},
      '{8'd128, 8'd0,   8'd77},  '{8'd255, 8'd128, 8'd200}, '{8'd0,   8'd255, 8'd255},
      '{8'd42,  8'd255, 8'd255}, '{8'd43,  8'd255, 8'd255}, '{8'd85,  8'd255, 8'd255},
      '{8'd86,  8'd255, 8'd255}, '{8'd127, 8'd255, 8'd255}, '{8'd128, 8'd255, 8'd255},
      '{8'd170, 8'd255, 8'd255}, '{8'd171, 8'd255, 8'd255}, '{8'd212, 8'd255, 8'd255},
      '{8'd213, 8'd255, 8'd255}, '{8'd254, 8'd255, 8'd255}, '{8'd100, 8'd1,   8'd1},
      '{8'd43,  8'd255, 8'd0},   '{8'd200, 8'd1,   8'd255}, '{8'd20,  8'd254, 8'd254},
      '{8'd255, 8'd255, 8'd0},   '{8'd170, 8'd170, 8'd85}
    };
    @(negedge clk);
    foreach (directed[k]) pending_pixels.push_back(directed[k]);
    // full stop: nothing new goes in until every result is back
    wait_drained();
    repeat (2) begin
      @(negedge clk);
      repeat (RandItems / 2) pending_pixels.push_back(rand_pixel());
      wait_drained();
    end
    all_loaded = 1'b1;
    repeat (TailItems) pending_pixels.push_back(rand_pixel());
    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0 && expected_rgb.size() == 0) begin
      $display("hsv_to_rgb_converter_test: PASS");
    end else begin
      $display("hsv_to_rgb_converter_test: FAIL");
    end
    $finish;
  end

endmodule

>>> hsv_to_rgb_converter.f
+incdir+hw/rtl
hw/rtl/hsvc_pkg.sv
hw/rtl/hsvc_if.sv
hw/rtl/hsvc_front.sv
hw/rtl/hsvc_queue.sv
hw/rtl/hsvc_back.sv
hw/rtl/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_test.sv
